// ===== design/htfd_pkg.sv =====
package htfd_pkg;

    typedef enum logic [1:0] {
        FRAME_OK      = 2'd0,
        FRAME_BUSY    = 2'd1,
        FRAME_CRC_ERR = 2'd2
    } frame_status_t;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam int          BUSY_BIT    = 7;
    localparam int          RAW_W       = 20;
    localparam int          HUM_C_W     = 14;
    localparam int          TEMP_C_W    = 15;
    localparam int          FRAC_BITS   = 20;
    localparam logic [13:0] HUM_SCALE   = 14'd10000;
    localparam logic [14:0] TEMP_SCALE  = 15'd20000;
    localparam logic [14:0] TEMP_OFFSET = 15'd5000;

    localparam logic [2:0] POS_IDLE   = 3'd0;
    localparam logic [2:0] POS_HUM_HI = 3'd1;
    localparam logic [2:0] POS_HUM_MD = 3'd2;
    localparam logic [2:0] POS_SPLIT  = 3'd3;
    localparam logic [2:0] POS_TMP_MD = 3'd4;
    localparam logic [2:0] POS_TMP_LO = 3'd5;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/humidity_temp_frame_decoder_core.sv =====
// Decodes the 7-byte reply of a humidity/temperature sensor, one byte per word:
// a status byte (flagged by s_tuser), five data bytes and a CRC-8 byte (poly 0x31,
// init 0xFF). A status byte with bit 7 set yields a busy result at once; otherwise
// one result follows the CRC byte with ok or CRC-mismatch status, the 20-bit raw
// humidity and temperature words and, when ok, humidity in 0.01 % and temperature
// in 0.01 degC. A data byte with no frame open is dropped; a new status byte drops
// any open frame. One byte is accepted every cycle unless a closing byte waits for
// a held result; a result passes from its closing byte through the input register,
// then the CRC/assembly and constant-scaling logic, into the result register.
module humidity_temp_frame_decoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [htfd_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic [htfd_pkg::S_TUSER_W-1:0]   s_tuser,   // [0] frame_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [htfd_pkg::M_TDATA_W-1:0]   m_tdata,   // [7:0] status_byte,
                                                        // [27:8] humidity_raw,
                                                        // [47:28] temperature_raw,
                                                        // [61:48] humidity_centi,
                                                        // [76:62] temperature_centi,
                                                        // [79:77] zero
    output logic [htfd_pkg::M_TUSER_W-1:0]   m_tuser    // [1:0] frame_status
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    logic [2:0]  pos_reg,    pos_next;
    logic        open_reg,   open_next;
    logic [7:0]  crc_reg,    crc_next;
    logic [7:0]  status_reg, status_next;
    logic [htfd_pkg::RAW_W-1:0] hum_reg,  hum_next;
    logic [htfd_pkg::RAW_W-1:0] temp_reg, temp_next;

    logic                        m_valid_reg;
    logic [htfd_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [htfd_pkg::M_TUSER_W-1:0] m_user_reg;

    logic                        emit;
    htfd_pkg::frame_status_t     emit_st;
    logic [7:0]                  emit_status;
    logic [htfd_pkg::RAW_W-1:0]  emit_hum;
    logic [htfd_pkg::RAW_W-1:0]  emit_temp;
    logic [33:0]                 hum_prod;
    logic [34:0]                 temp_prod;
    logic [htfd_pkg::HUM_C_W-1:0]  hum_centi;
    logic [htfd_pkg::TEMP_C_W-1:0] temp_scaled;
    logic signed [htfd_pkg::TEMP_C_W-1:0] temp_centi;
    logic out_free;
    logic proc;

    always_comb begin
        pos_next    = pos_reg;
        open_next   = open_reg;
        crc_next    = crc_reg;
        status_next = status_reg;
        hum_next    = hum_reg;
        temp_next   = temp_reg;
        emit        = 1'b0;
        emit_st     = htfd_pkg::FRAME_OK;
        emit_status = status_reg;
        emit_hum    = hum_reg;
        emit_temp   = temp_reg;
        if (in_start_reg) begin
            status_next = in_byte_reg;
            crc_next    = htfd_pkg::crc8_update(htfd_pkg::CRC_INIT, in_byte_reg);
            hum_next    = '0;
            temp_next   = '0;
            emit_status = in_byte_reg;
            if (in_byte_reg[htfd_pkg::BUSY_BIT]) begin
                open_next = 1'b0;
                pos_next  = htfd_pkg::POS_IDLE;
                emit      = 1'b1;
                emit_st   = htfd_pkg::FRAME_BUSY;
                emit_hum  = '0;
                emit_temp = '0;
            end else begin
                open_next = 1'b1;
                pos_next  = htfd_pkg::POS_HUM_HI;
            end
        end else if (open_reg) begin
            crc_next = htfd_pkg::crc8_update(crc_reg, in_byte_reg);
            pos_next = pos_reg + 3'd1;
            case (pos_reg)
                htfd_pkg::POS_HUM_HI: begin
                    hum_next = {in_byte_reg, 12'd0};
                end
                htfd_pkg::POS_HUM_MD: begin
                    hum_next = hum_reg | {8'd0, in_byte_reg, 4'd0};
                end
                htfd_pkg::POS_SPLIT: begin
                    hum_next  = hum_reg | {16'd0, in_byte_reg[7:4]};
                    temp_next = {16'd0, in_byte_reg[3:0]};
                end
                htfd_pkg::POS_TMP_MD, htfd_pkg::POS_TMP_LO: begin
                    temp_next = {temp_reg[11:0], in_byte_reg};
                end
                default: begin
                    crc_next  = crc_reg;
                    open_next = 1'b0;
                    pos_next  = htfd_pkg::POS_IDLE;
                    emit      = 1'b1;
                    emit_st   = (in_byte_reg == crc_reg) ? htfd_pkg::FRAME_OK
                                                         : htfd_pkg::FRAME_CRC_ERR;
                end
            endcase
        end
    end

    assign hum_prod    = {14'd0, emit_hum} * {20'd0, htfd_pkg::HUM_SCALE};
    assign temp_prod   = {15'd0, emit_temp} * {20'd0, htfd_pkg::TEMP_SCALE};
    assign hum_centi   = hum_prod[htfd_pkg::FRAC_BITS +: htfd_pkg::HUM_C_W];
    assign temp_scaled = temp_prod[htfd_pkg::FRAC_BITS +: htfd_pkg::TEMP_C_W];
    assign temp_centi  = $signed(temp_scaled - htfd_pkg::TEMP_OFFSET);

    assign out_free = !m_valid_reg || m_tready;
    assign proc     = in_valid_reg && (!emit || out_free);
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata[7:0];
            in_start_reg <= s_tuser[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= htfd_pkg::POS_IDLE;
            open_reg   <= 1'b0;
            crc_reg    <= htfd_pkg::CRC_INIT;
            status_reg <= '0;
            hum_reg    <= '0;
            temp_reg   <= '0;
        end else if (proc) begin
            pos_reg    <= pos_next;
            open_reg   <= open_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
            hum_reg    <= hum_next;
            temp_reg   <= temp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= proc && emit;
        end
        if (out_free && proc && emit) begin
            m_user_reg <= emit_st;
            if (emit_st == htfd_pkg::FRAME_OK) begin
                m_data_reg <= {3'd0, temp_centi, hum_centi, emit_temp, emit_hum, emit_status};
            end else begin
                m_data_reg <= {3'd0, {htfd_pkg::TEMP_C_W{1'b0}}, {htfd_pkg::HUM_C_W{1'b0}},
                               emit_temp, emit_hum, emit_status};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
